// ----- design/shp_pkg.sv -----
// Shared types and constants of the SOCKS5 header parser.
`timescale 1ns / 1ps

package shp_pkg;

  // Protocol constants
  localparam logic [7:0] SOCKS_VER   = 8'h05;
  localparam logic [7:0] CMD_CONNECT = 8'h01;
  localparam logic [7:0] ATYP_IPV4   = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN = 8'h03;
  localparam logic [7:0] ATYP_IPV6   = 8'h04;
  localparam logic [7:0] LEN_IPV4    = 8'd4;
  localparam logic [7:0] LEN_IPV6    = 8'd16;

  // Mode register codes; any other code parses a TCP request
  localparam logic [1:0] MODE_GREETING = 2'd0;
  localparam logic [1:0] MODE_REQUEST  = 2'd1;
  localparam logic [1:0] MODE_UDP      = 2'd2;

  // Address kind codes as reported on addr_type
  localparam logic [1:0] KIND_IPV4   = 2'd0;
  localparam logic [1:0] KIND_DOMAIN = 2'd1;
  localparam logic [1:0] KIND_IPV6   = 2'd2;

  // Configuration register indexes
  localparam logic CFG_MODE       = 1'b0;
  localparam logic CFG_REQ_METHOD = 1'b1;

  typedef enum logic [1:0] {
    EV_ADDR = 2'd0,
    EV_DONE = 2'd1,
    EV_ERR  = 2'd2
  } event_e;

  typedef enum logic [2:0] {
    ERR_VERSION   = 3'd0,
    ERR_NO_METHOD = 3'd1,
    ERR_COMMAND   = 3'd2,
    ERR_ATYP      = 3'd3,
    ERR_TRUNCATED = 3'd4,
    ERR_RESERVED  = 3'd5
  } err_e;

  // One input byte request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } shp_in_t;

  // One result
  typedef struct packed {
    event_e      event_res;
    logic [7:0]  addr_byte;
    logic [1:0]  addr_type;
    logic [15:0] dest_port;
    logic [8:0]  header_length;
    err_e        error_code;
  } shp_out_t;

  // Configuration values seen by the parser
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] required_method;
  } shp_cfg_t;

endpackage

// ----- design/socks5_header_parser.sv -----
// Top level of the SOCKS5 header parser: input register, parser, result register.
// Path: a byte accepted into the input register is parsed combinationally from there,
//   and its result is captured in the result register and shown from then on.
// Throughput: one byte per cycle, as long as the receiver does not stall the output.
// Reset: asynchronous, active low; clears control and parser state and sets
//   mode to TCP request and the required method to zero.
`timescale 1ns / 1ps

module socks5_header_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  shp_pkg::shp_in_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output shp_pkg::shp_out_t out_res_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [7:0]        cfg_data_i
);
  import shp_pkg::*;

  logic     in_valid_q;
  shp_in_t  in_req_q;
  logic     out_valid_q;
  shp_out_t out_res_q;
  logic     advance;
  logic     consume;
  logic     accept;
  logic     res_valid;
  shp_out_t res;
  shp_cfg_t cfg;

  // Pipeline control: the held byte moves on when the result slot frees up
  assign advance    = !out_valid_q || !out_stall_i;
  assign consume    = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  shp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  shp_parse_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (consume),
    .req_i       (in_req_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (consume) begin
        in_valid_q <= 1'b0;
      end
      if (consume) begin
        out_valid_q <= res_valid;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_req_q <= in_req_i;
    end
    if (consume) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

// ----- design/shp_cfg_regs.sv -----
// Configuration registers of the SOCKS5 header parser.
`timescale 1ns / 1ps

module shp_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  output logic              cfg_ready_o,
  output shp_pkg::shp_cfg_t cfg_o
);
  import shp_pkg::*;

  logic [1:0] mode_q;
  logic [7:0] req_method_q;

  assign cfg_ready_o = 1'b1;

  // Register writes, always accepted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_REQUEST;
      req_method_q <= 8'h00;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MODE:       mode_q       <= cfg_data_i[1:0];
        CFG_REQ_METHOD: req_method_q <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  assign cfg_o.mode            = mode_q;
  assign cfg_o.required_method = req_method_q;

endmodule

// ----- design/shp_parse_core.sv -----
// Per-byte header parser state machine and result decode.
`timescale 1ns / 1ps

module shp_parse_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  shp_pkg::shp_in_t  req_i,
  input  shp_pkg::shp_cfg_t cfg_i,
  output logic              res_valid_o,
  output shp_pkg::shp_out_t res_o
);
  import shp_pkg::*;

  typedef enum logic [3:0] {
    PH_START     = 4'd0,
    PH_G_COUNT   = 4'd1,
    PH_G_METHODS = 4'd2,
    PH_R_CMD     = 4'd3,
    PH_R_RSV     = 4'd4,
    PH_ATYP      = 4'd5,
    PH_DLEN      = 4'd6,
    PH_ADDR      = 4'd7,
    PH_PORT_HI   = 4'd8,
    PH_PORT_LO   = 4'd9,
    PH_U_RSV     = 4'd10,
    PH_U_FRAG    = 4'd11
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [8:0]  count_q, count_d;
  logic [7:0]  remain_q, remain_d;
  logic [1:0]  kind_q, kind_d;
  logic [7:0]  port_hi_q, port_hi_d;
  logic        seen_q, seen_d;
  logic        done_q, done_d;
  logic [7:0]  b;
  logic [7:0]  rem_dec;
  logic        seen_now;

  assign b        = req_i.data_byte;
  assign rem_dec  = remain_q - 8'd1;
  assign seen_now = seen_q | (b == cfg_i.required_method);

  // Next state and result for one byte
  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    remain_d    = remain_q;
    kind_d      = kind_q;
    port_hi_d   = port_hi_q;
    seen_d      = seen_q;
    done_d      = done_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (!done_q) begin
      count_d = count_q + 9'd1;
      unique case (phase_q)
        PH_START: begin
          if (cfg_i.mode == MODE_UDP) begin
            if (b != 8'h00) begin
              res_valid_o      = 1'b1;
              res_o.event_res  = EV_ERR;
              res_o.error_code = ERR_RESERVED;
              done_d           = 1'b1;
            end else begin
              phase_d = PH_U_RSV;
            end
          end else if (b != SOCKS_VER) begin
            res_valid_o      = 1'b1;
            res_o.event_res  = EV_ERR;
            res_o.error_code = ERR_VERSION;
            done_d           = 1'b1;
          end else if (cfg_i.mode == MODE_GREETING) begin
            phase_d = PH_G_COUNT;
          end else begin
            phase_d = PH_R_CMD;
          end
        end
        PH_G_COUNT: begin
          if (b == 8'h00) begin
            res_valid_o      = 1'b1;
            res_o.event_res  = EV_ERR;
            res_o.error_code = ERR_NO_METHOD;
            done_d           = 1'b1;
          end else begin
            remain_d = b;
            seen_d   = 1'b0;
            phase_d  = PH_G_METHODS;
          end
        end
        PH_G_METHODS: begin
          seen_d   = seen_now;
          remain_d = rem_dec;
          if (rem_dec == 8'd0) begin
            res_valid_o = 1'b1;
            done_d      = 1'b1;
            if (seen_now) begin
              res_o.event_res     = EV_DONE;
              res_o.header_length = count_d;
            end else begin
              res_o.event_res  = EV_ERR;
              res_o.error_code = ERR_NO_METHOD;
            end
          end
        end
        PH_R_CMD: begin
          if (b != CMD_CONNECT) begin
            res_valid_o      = 1'b1;
            res_o.event_res  = EV_ERR;
            res_o.error_code = ERR_COMMAND;
            done_d           = 1'b1;
          end else begin
            phase_d = PH_R_RSV;
          end
        end
        PH_R_RSV: phase_d = PH_ATYP;
        PH_U_RSV, PH_U_FRAG: begin
          if (b != 8'h00) begin
            res_valid_o      = 1'b1;
            res_o.event_res  = EV_ERR;
            res_o.error_code = ERR_RESERVED;
            done_d           = 1'b1;
          end else begin
            phase_d = (phase_q == PH_U_RSV) ? PH_U_FRAG : PH_ATYP;
          end
        end
        PH_ATYP: begin
          if (b == ATYP_IPV4) begin
            kind_d   = KIND_IPV4;
            remain_d = LEN_IPV4;
            phase_d  = PH_ADDR;
          end else if (b == ATYP_DOMAIN) begin
            kind_d  = KIND_DOMAIN;
            phase_d = PH_DLEN;
          end else if (b == ATYP_IPV6) begin
            kind_d   = KIND_IPV6;
            remain_d = LEN_IPV6;
            phase_d  = PH_ADDR;
          end else begin
            res_valid_o      = 1'b1;
            res_o.event_res  = EV_ERR;
            res_o.error_code = ERR_ATYP;
            done_d           = 1'b1;
          end
        end
        PH_DLEN: begin
          // domain length byte goes out as the first address byte
          res_valid_o     = 1'b1;
          res_o.event_res = EV_ADDR;
          res_o.addr_byte = b;
          res_o.addr_type = kind_q;
          remain_d        = b;
          phase_d         = (b != 8'h00) ? PH_ADDR : PH_PORT_HI;
        end
        PH_ADDR: begin
          res_valid_o     = 1'b1;
          res_o.event_res = EV_ADDR;
          res_o.addr_byte = b;
          res_o.addr_type = kind_q;
          remain_d        = rem_dec;
          if (rem_dec == 8'd0) begin
            phase_d = PH_PORT_HI;
          end
        end
        PH_PORT_HI: begin
          port_hi_d = b;
          phase_d   = PH_PORT_LO;
        end
        PH_PORT_LO: begin
          res_valid_o         = 1'b1;
          res_o.event_res     = EV_DONE;
          res_o.addr_type     = kind_q;
          res_o.dest_port     = {port_hi_q, b};
          res_o.header_length = count_d;
          done_d              = 1'b1;
        end
        default: phase_d = PH_START;
      endcase
    end

    // End of buffer: flag an unfinished header, then rearm
    if (req_i.last) begin
      if (!done_d) begin
        res_valid_o      = 1'b1;
        res_o            = '0;
        res_o.event_res  = EV_ERR;
        res_o.error_code = ERR_TRUNCATED;
      end
      phase_d   = PH_START;
      count_d   = '0;
      remain_d  = '0;
      kind_d    = KIND_IPV4;
      port_hi_d = '0;
      seen_d    = 1'b0;
      done_d    = 1'b0;
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_START;
      count_q   <= '0;
      remain_q  <= '0;
      kind_q    <= KIND_IPV4;
      port_hi_q <= '0;
      seen_q    <= 1'b0;
      done_q    <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      count_q   <= count_d;
      remain_q  <= remain_d;
      kind_q    <= kind_d;
      port_hi_q <= port_hi_d;
      seen_q    <= seen_d;
      done_q    <= done_d;
    end
  end

endmodule

// ----- tb/shp_header_checker.sv -----
// Checker of the SOCKS5 header parser: predicts each byte's result and compares it.
`timescale 1ns / 1ps

module shp_header_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  shp_pkg::shp_in_t  in_req_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  shp_pkg::shp_out_t out_res_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic              cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  output int                mismatch_count_o,
  output int                pending_o
);
  import shp_pkg::*;

  // Parser position within the current header
  typedef enum logic [3:0] {
    PH_START,
    PH_G_COUNT,
    PH_G_METHODS,
    PH_R_CMD,
    PH_R_RSV,
    PH_ATYP,
    PH_DLEN,
    PH_ADDR,
    PH_PORT_HI,
    PH_PORT_LO,
    PH_U_RSV,
    PH_U_FRAG
  } parse_phase_e;

  // Register copies
  logic [1:0]   cfg_mode;
  logic [7:0]   cfg_method;

  // Header state
  parse_phase_e phase;
  logic [8:0]   hdr_count;
  logic [7:0]   remaining;
  logic [1:0]   addr_kind;
  logic [15:0]  port_acc;
  logic         method_found;
  logic         hdr_over;

  // Result of the byte being parsed
  logic         step_has_result;
  shp_out_t     step_result;

  shp_out_t     expected_results[$];
  int           mismatches = 0;
  int           outstanding = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = outstanding;

  task automatic report(input string msg);
    if (mismatches < 100) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  task automatic new_header();
    phase        = PH_START;
    hdr_count    = '0;
    remaining    = '0;
    addr_kind    = KIND_IPV4;
    port_acc     = '0;
    method_found = 1'b0;
    hdr_over     = 1'b0;
  endtask

  task automatic header_error(input err_e code);
    step_has_result        = 1'b1;
    step_result            = '0;
    step_result.event_res  = EV_ERR;
    step_result.error_code = code;
    hdr_over               = 1'b1;
  endtask

  task automatic header_done(input logic [1:0] kind, input logic [15:0] port);
    step_has_result           = 1'b1;
    step_result               = '0;
    step_result.event_res     = EV_DONE;
    step_result.addr_type     = kind;
    step_result.dest_port     = port;
    step_result.header_length = hdr_count;
    hdr_over                  = 1'b1;
  endtask

  task automatic addr_out(input logic [7:0] b);
    step_has_result       = 1'b1;
    step_result           = '0;
    step_result.event_res = EV_ADDR;
    step_result.addr_byte = b;
    step_result.addr_type = addr_kind;
  endtask

  // One byte through the header parser
  task automatic parse_byte(input shp_in_t req);
    logic [7:0] b;
    b = req.data_byte;
    step_has_result = 1'b0;
    step_result = '0;
    if (!hdr_over) begin
      hdr_count = hdr_count + 9'd1;
      case (phase)
        PH_START: begin
          // mode is only looked at on the first byte of a header
          if (cfg_mode == MODE_GREETING) begin
            if (b != SOCKS_VER) header_error(ERR_VERSION); else phase = PH_G_COUNT;
          end else if (cfg_mode == MODE_UDP) begin
            if (b != 8'd0) header_error(ERR_RESERVED); else phase = PH_U_RSV;
          end else begin
            if (b != SOCKS_VER) header_error(ERR_VERSION); else phase = PH_R_CMD;
          end
        end
        PH_G_COUNT: begin
          if (b == 8'd0) begin
            header_error(ERR_NO_METHOD);
          end else begin
            remaining    = b;
            method_found = 1'b0;
            phase        = PH_G_METHODS;
          end
        end
        PH_G_METHODS: begin
          // required method is read live on every method byte
          if (b == cfg_method) method_found = 1'b1;
          remaining = remaining - 8'd1;
          if (remaining == 8'd0) begin
            if (method_found) header_done(KIND_IPV4, 16'd0);
            else header_error(ERR_NO_METHOD);
          end
        end
        PH_R_CMD: begin
          if (b != CMD_CONNECT) header_error(ERR_COMMAND); else phase = PH_R_RSV;
        end
        PH_R_RSV: phase = PH_ATYP;
        PH_U_RSV: begin
          if (b != 8'd0) header_error(ERR_RESERVED); else phase = PH_U_FRAG;
        end
        PH_U_FRAG: begin
          if (b != 8'd0) header_error(ERR_RESERVED); else phase = PH_ATYP;
        end
        PH_ATYP: begin
          if (b == ATYP_IPV4) begin
            addr_kind = KIND_IPV4;
            remaining = LEN_IPV4;
            phase     = PH_ADDR;
          end else if (b == ATYP_DOMAIN) begin
            addr_kind = KIND_DOMAIN;
            phase     = PH_DLEN;
          end else if (b == ATYP_IPV6) begin
            addr_kind = KIND_IPV6;
            remaining = LEN_IPV6;
            phase     = PH_ADDR;
          end else begin
            header_error(ERR_ATYP);
          end
        end
        PH_DLEN: begin
          // domain length goes out as an address byte; zero skips to the port
          addr_out(b);
          remaining = b;
          phase     = (b != 8'd0) ? PH_ADDR : PH_PORT_HI;
        end
        PH_ADDR: begin
          addr_out(b);
          remaining = remaining - 8'd1;
          if (remaining == 8'd0) phase = PH_PORT_HI;
        end
        PH_PORT_HI: begin
          port_acc = {b, 8'd0};
          phase    = PH_PORT_LO;
        end
        PH_PORT_LO: begin
          port_acc = {port_acc[15:8], b};
          header_done(addr_kind, port_acc);
        end
        default: phase = PH_START;
      endcase
    end
    // last flag ends the buffer; an open header is truncated
    if (req.last) begin
      if (!hdr_over) header_error(ERR_TRUNCATED);
      new_header();
    end
  endtask

  // Watch the three channels
  always @(posedge clk_i or negedge rst_ni) begin : watch
    shp_out_t want;
    if (!rst_ni) begin
      cfg_mode   = MODE_REQUEST;
      cfg_method = '0;
      new_header();
      expected_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_MODE) cfg_mode = cfg_data_i[1:0];
        else cfg_method = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        parse_byte(in_req_i);
        if (step_has_result) expected_results = {expected_results, step_result};
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report($sformatf("result with nothing expected, event %0d", out_res_i.event_res));
        end else begin
          want = expected_results.pop_front();
          check_field("event_res", out_res_i.event_res, want.event_res);
          check_field("addr_byte", out_res_i.addr_byte, want.addr_byte);
          check_field("addr_type", out_res_i.addr_type, want.addr_type);
          check_field("dest_port", out_res_i.dest_port, want.dest_port);
          check_field("header_length", out_res_i.header_length, want.header_length);
          check_field("error_code", out_res_i.error_code, want.error_code);
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

// ----- tb/tb.sv -----
// Top of the SOCKS5 header parser testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import shp_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 150;
  localparam int PHASE_BYTES  = 230;
  localparam int NUM_PHASES   = 8;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  shp_in_t    in_req_i;
  logic       out_valid_o;
  logic       out_stall_i;
  shp_out_t   out_res_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic       cfg_index_i;
  logic [7:0] cfg_data_i;

  int         mismatch_count;
  int         pending;

  // Register values as last written, for building headers
  logic [1:0] cur_mode;
  logic [7:0] cur_method;

  logic [7:0] frame[$];
  int         burst_left;
  bit         gaps_on;
  bit         hold_go;

  socks5_header_parser i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  shp_header_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_req_i         (in_req_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_res_i        (out_res_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [7:0] rand_byte();
    logic [31:0] r;
    r = $urandom;
    return r[7:0];
  endfunction

  // Add one byte at the end of the buffer being built
  task automatic append_byte(input logic [7:0] b);
    frame = {frame, b};
  endtask

  // Offer one byte request; returns after the edge that accepts it
  task automatic offer_byte(input logic [7:0] b, input logic is_last);
    shp_in_t req;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on && $urandom_range(0, 2) != 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk_i);
      end
    end
    burst_left--;
    req.data_byte = b;
    req.last      = is_last;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame.size(); i++) offer_byte(frame[i], i == frame.size() - 1);
  endtask

  // Stop offering and wait until every result is in and the pipe is quiet
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_MODE) cur_mode = val[1:0];
    else cur_method = val;
  endtask

  // ATYP, address and port; domains are mostly short
  task automatic add_address();
    int sel;
    int n;
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      append_byte(ATYP_IPV4);
      repeat (4) append_byte(rand_byte());
    end else if (sel < 60) begin
      append_byte(ATYP_IPV6);
      repeat (16) append_byte(rand_byte());
    end else if (sel < 92) begin
      append_byte(ATYP_DOMAIN);
      n = ($urandom_range(0, 39) == 0) ? $urandom_range(100, 255) : $urandom_range(0, 12);
      append_byte(n[7:0]);
      repeat (n) append_byte(rand_byte());
    end else begin
      append_byte(rand_byte());
    end
    append_byte(rand_byte());
    append_byte(rand_byte());
  endtask

  // One buffer: mostly a well-formed header of the current mode, sometimes damaged
  task automatic build_frame();
    int sel;
    int n;
    int hit;
    int cut;
    frame.delete();
    if ($urandom_range(0, 99) < 6) begin
      repeat ($urandom_range(1, 6)) append_byte(rand_byte());
      return;
    end
    case (cur_mode)
      MODE_GREETING: begin
        sel = $urandom_range(0, 39);
        n   = (sel == 0) ? 0 : (sel == 1) ? 255 : $urandom_range(1, 6);
        hit = -1;
        if (n > 0 && $urandom_range(0, 3) != 0) hit = $urandom_range(0, n - 1);
        append_byte(SOCKS_VER);
        append_byte(n[7:0]);
        for (int i = 0; i < n; i++) append_byte((i == hit) ? cur_method : rand_byte());
      end
      MODE_UDP: begin
        repeat (3) append_byte(8'd0);
        add_address();
      end
      default: begin
        append_byte(SOCKS_VER);
        append_byte(($urandom_range(0, 99) < 85) ? CMD_CONNECT : rand_byte());
        append_byte(rand_byte());
        add_address();
      end
    endcase
    if ($urandom_range(0, 9) == 0) frame[$urandom_range(0, frame.size() - 1)] = rand_byte();
    if ($urandom_range(0, 9) == 0 && frame.size() > 1) begin
      cut = $urandom_range(1, frame.size() - 1);
      while (frame.size() > cut) frame.delete(frame.size() - 1);
    end
    // trailing bytes are ignored until the last flag
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 5)) append_byte(rand_byte());
  endtask

  // Receiver stall pattern, with one long hold-off on request
  initial begin : receiver_stall
    int seg_kind;
    int seg_len;
    bit hold_taken;
    hold_taken  = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      seg_kind = $urandom_range(0, 3);
      seg_len  = $urandom_range(4, 40);
      repeat (seg_len) begin
        @(negedge clk_i);
        case (seg_kind)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 1) == 0);
          default: out_stall_i <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int phase_sent;
    logic [1:0] mode_sel;
    logic [7:0] method_sel;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_MODE;
    cfg_data_i  = '0;
    cur_mode    = MODE_REQUEST;
    cur_method  = '0;
    burst_left  = 0;
    gaps_on     = 1'b1;
    hold_go     = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset config is TCP request, method zero
    frame = '{8'h04};                      // bad version on the last byte itself
    send_frame();
    frame = '{SOCKS_VER};                  // truncated after version
    send_frame();
    frame = '{SOCKS_VER, 8'h02};           // BIND is not supported
    send_frame();
    frame = '{SOCKS_VER, CMD_CONNECT, 8'hFF, 8'h02};  // reserved unchecked, bad ATYP
    send_frame();
    // zero-length domain, port 0xffff, one ignored byte after the header
    frame = '{SOCKS_VER, CMD_CONNECT, 8'h00, ATYP_DOMAIN, 8'h00, 8'hFF, 8'hFF, 8'h33};
    send_frame();
    wait_drained();
    write_reg(CFG_MODE, {6'd0, MODE_UDP});
    frame = '{8'h00, 8'h00, 8'h01};        // nonzero fragment
    send_frame();
    wait_drained();
    write_reg(CFG_MODE, {6'd0, MODE_GREETING});
    write_reg(CFG_REQ_METHOD, 8'hFF);
    frame = '{SOCKS_VER, 8'h00};           // empty method list
    send_frame();
    frame = '{SOCKS_VER, 8'h01, 8'hFF};
    send_frame();
    wait_drained();
    write_reg(CFG_MODE, 8'd3);             // unnamed code, parsed as a TCP request
    frame = '{SOCKS_VER, CMD_CONNECT, 8'h00, ATYP_IPV6};
    send_frame();
    wait_drained();

    // Random phases, each with its own register settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      mode_sel   = 2'((p + 1) % 4);
      method_sel = (p % 3 == 0) ? 8'h00 : (p % 3 == 1) ? 8'hFF : rand_byte();
      write_reg(CFG_MODE, {6'd0, mode_sel});
      write_reg(CFG_REQ_METHOD, method_sel);
      gaps_on = (p != 0 && p != 4);
      // first phase: receiver holds off while the sender keeps offering
      if (p == 0) hold_go = 1'b1;
      phase_sent = 0;
      while (phase_sent < PHASE_BYTES) begin
        build_frame();
        send_frame();
        phase_sent += frame.size();
      end
      wait_drained();
    end

    if (mismatch_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
